[src/qtbu_pkg.sv]
`default_nettype none

package qtbu_pkg;

    // default table shape
    localparam int DEF_NUM_STATES  = 256;
    localparam int DEF_NUM_ACTIONS = 4;

    // fixed field widths
    localparam int VAL_W     = 32;
    localparam int FRAC_BITS = 16;
    localparam int DISC_W    = 17;
    localparam int SHIFT_W   = 4;
    localparam int LIMIT_W   = 31;
    localparam int CNT_W     = 32;

    // apb port
    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    // register reset values
    localparam logic [DISC_W-1:0]  DISCOUNT_RST    = 17'd64881;
    localparam logic [SHIFT_W-1:0] LEARN_SHIFT_RST = 4'd4;
    localparam logic [LIMIT_W-1:0] VALUE_LIMIT_RST = 31'd8388608;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_DISCOUNT    = 2'd0,
        REG_LEARN_SHIFT = 2'd1,
        REG_VALUE_LIMIT = 2'd2
    } reg_idx_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LAND,
        ST_MUL,
        ST_TARGET,
        ST_DIFF,
        ST_SCALE,
        ST_SUM,
        ST_CLAMP,
        ST_FINISH
    } fsm_t;

endpackage

`default_nettype wire

[src/q_table_bellman_update_unit.sv]
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    s_tdata, s_tuser = command, s_tlast = done_req
// m_*       out  m_tvalid / m_tready    m_tdata
// apb       in   psel & penable         paddr, pwdata, pwrite, prdata, pready
//
// the single read port of the table is walked once per row entry, and an update also reads
// the current entry; then the update goes through multiply, target, difference, scale, sum
// and clamp steps. after reset the table is swept to zero, with s_tready low; apb writes
// are taken meanwhile.
// a finished word waits in the output register while the next item is taken in;
// the sequencer only stalls at its last step while that register is still full.
`default_nettype none

module q_table_bellman_update_unit #(
    parameter int NUM_STATES  = qtbu_pkg::DEF_NUM_STATES,
    parameter int NUM_ACTIONS = qtbu_pkg::DEF_NUM_ACTIONS,
    localparam int SW      = $clog2(NUM_STATES),
    localparam int ACTW    = $clog2(NUM_ACTIONS),
    localparam int IN_BITS = 2 * SW + ACTW + qtbu_pkg::VAL_W,
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = ACTW + qtbu_pkg::VAL_W + 1 + 2 * qtbu_pkg::CNT_W,
    localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // state_index, action, reward, next_state
    input  wire logic [IN_W-1:0]             s_tdata,
    // command
    input  wire logic                        s_tuser,
    // done_req
    input  wire logic                        s_tlast,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // best_action, entry_value, clamp_hit, update_total, clamp_total
    output logic [OUT_W-1:0]                 m_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [qtbu_pkg::APB_AW-1:0] paddr,
    input  wire logic [qtbu_pkg::APB_DW-1:0] pwdata,
    output logic [qtbu_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);
    import qtbu_pkg::*;

    localparam int AW    = SW + ACTW;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = $clog2(NUM_ACTIONS + 1);
    localparam int PW    = DISC_W + 1 + VAL_W;

    // input field slices
    logic [SW-1:0]   in_state;
    logic [ACTW-1:0] in_action;
    logic [VAL_W-1:0] in_reward;
    logic [SW-1:0]   in_next;
    logic [SW-1:0]   in_state_mod;
    logic [ACTW-1:0] in_action_mod;
    logic [SW-1:0]   in_next_mod;

    assign in_state  = s_tdata[SW-1:0];
    assign in_action = s_tdata[SW +: ACTW];
    assign in_reward = s_tdata[SW+ACTW +: VAL_W];
    assign in_next   = s_tdata[SW+ACTW+VAL_W +: SW];

    // index wrap onto the table size (value is below twice the size)
    assign in_state_mod = ({1'b0, in_state} >= (SW+1)'(NUM_STATES))
        ? SW'({1'b0, in_state} - (SW+1)'(NUM_STATES)) : in_state;
    assign in_next_mod = ({1'b0, in_next} >= (SW+1)'(NUM_STATES))
        ? SW'({1'b0, in_next} - (SW+1)'(NUM_STATES)) : in_next;
    assign in_action_mod = ({1'b0, in_action} >= (ACTW+1)'(NUM_ACTIONS))
        ? ACTW'({1'b0, in_action} - (ACTW+1)'(NUM_ACTIONS)) : in_action;

    // configuration registers
    logic [DISC_W-1:0]  discount_reg;
    logic [SHIFT_W-1:0] learn_shift_reg;
    logic [LIMIT_W-1:0] value_limit_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discount_reg    <= DISCOUNT_RST;
            learn_shift_reg <= LEARN_SHIFT_RST;
            value_limit_reg <= VALUE_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_DISCOUNT:    discount_reg    <= pwdata[DISC_W-1:0];
                REG_LEARN_SHIFT: learn_shift_reg <= pwdata[SHIFT_W-1:0];
                REG_VALUE_LIMIT: value_limit_reg <= pwdata[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (cfg_idx)
            REG_DISCOUNT:    prdata = APB_DW'(discount_reg);
            REG_LEARN_SHIFT: prdata = APB_DW'(learn_shift_reg);
            REG_VALUE_LIMIT: prdata = APB_DW'(value_limit_reg);
            default:         prdata = '0;
        endcase
    end

    // item registers
    fsm_t                    state_reg, state_next;
    logic                    cmd_reg;
    logic [SW-1:0]           st_reg;
    logic [SW-1:0]           nx_reg;
    logic [ACTW-1:0]         act_reg;
    logic signed [VAL_W-1:0] reward_reg;
    logic                    done_reg;

    // scan bookkeeping
    logic [CW-1:0]   rd_cnt_reg, rd_cnt_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic            rd_valid_reg;
    logic            rd_qcur_reg;
    logic [ACTW-1:0] rd_idx_reg;
    logic [VAL_W-1:0] rd_data_reg;

    // datapath registers
    logic signed [VAL_W-1:0] best_val_reg;
    logic [ACTW-1:0]         best_idx_reg;
    logic signed [VAL_W-1:0] qcur_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [VAL_W-1:0] target_reg;
    logic signed [VAL_W-1:0] diff_reg;
    logic signed [VAL_W-1:0] delta_reg;
    logic signed [VAL_W-1:0] sum_reg;
    logic signed [VAL_W-1:0] newval_reg;
    logic                    hit_reg;

    // counters and output register
    logic [CNT_W-1:0]  upd_cnt_reg, upd_cnt_next;
    logic [CNT_W-1:0]  clp_cnt_reg, clp_cnt_next;
    logic              m_tvalid_reg;
    logic [ACTW-1:0]   out_act_reg;
    logic [VAL_W-1:0]  out_val_reg;
    logic              out_hit_reg;
    logic [CNT_W-1:0]  out_upd_reg;
    logic [CNT_W-1:0]  out_clp_reg;

    // sequencer outputs
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    logic             rd_is_qcur;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic [VAL_W-1:0] mem_wr_data;
    logic             load_out;
    logic             out_free;
    logic             in_take;
    logic [SW-1:0]    scan_row;
    logic             scan_last;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign in_take   = s_tvalid && s_tready;
    assign scan_row  = cmd_reg ? st_reg : nx_reg;
    assign scan_last = (cmd_reg && (rd_cnt_reg == CW'(NUM_ACTIONS - 1)))
        || (rd_cnt_reg == CW'(NUM_ACTIONS));

    // next state and control
    always_comb
    begin
        state_next    = state_reg;
        rd_cnt_next   = rd_cnt_reg;
        clr_addr_next = clr_addr_reg;
        s_tready      = 1'b0;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = {scan_row, rd_cnt_reg[ACTW-1:0]};
        rd_is_qcur    = 1'b0;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = {st_reg, act_reg};
        mem_wr_data   = newval_reg;
        load_out      = 1'b0;
        upd_cnt_next  = upd_cnt_reg;
        clp_cnt_next  = clp_cnt_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = clr_addr_reg;
                mem_wr_data   = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    rd_cnt_next = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                mem_rd_en = 1'b1;
                if (rd_cnt_reg == CW'(NUM_ACTIONS))
                begin
                    mem_rd_addr = {st_reg, act_reg};
                    rd_is_qcur  = 1'b1;
                end
                rd_cnt_next = rd_cnt_reg + CW'(1);
                if (scan_last)
                    state_next = ST_LAND;
            end
            ST_LAND:   state_next = cmd_reg ? ST_FINISH : ST_MUL;
            ST_MUL:    state_next = ST_TARGET;
            ST_TARGET: state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_SUM;
            ST_SUM:    state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    if (!cmd_reg)
                    begin
                        mem_wr_en    = 1'b1;
                        upd_cnt_next = upd_cnt_reg + CNT_W'(1);
                        clp_cnt_next = clp_cnt_reg + CNT_W'(hit_reg);
                    end
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            rd_cnt_reg   <= '0;
            clr_addr_reg <= '0;
            rd_valid_reg <= 1'b0;
            upd_cnt_reg  <= '0;
            clp_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_cnt_reg   <= rd_cnt_next;
            clr_addr_reg <= clr_addr_next;
            rd_valid_reg <= mem_rd_en;
            upd_cnt_reg  <= upd_cnt_next;
            clp_cnt_reg  <= clp_cnt_next;
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // value table, one read and one write port
    logic [VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            mem[mem_wr_addr] <= mem_wr_data;
        if (mem_rd_en)
            rd_data_reg <= mem[mem_rd_addr];
    end

    // item capture and read tags
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg    <= s_tuser;
            st_reg     <= in_state_mod;
            nx_reg     <= in_next_mod;
            act_reg    <= in_action_mod;
            reward_reg <= $signed(in_reward);
            done_reg   <= s_tlast;
        end
        if (mem_rd_en)
        begin
            rd_qcur_reg <= rd_is_qcur;
            rd_idx_reg  <= rd_cnt_reg[ACTW-1:0];
        end
    end

    // row maximum and current entry, first strict maximum wins
    always_ff @(posedge clk)
    begin
        if (rd_valid_reg && rd_qcur_reg)
            qcur_reg <= $signed(rd_data_reg);
        if (rd_valid_reg && !rd_qcur_reg
            && ((rd_idx_reg == '0) || ($signed(rd_data_reg) > best_val_reg)))
        begin
            best_val_reg <= $signed(rd_data_reg);
            best_idx_reg <= rd_idx_reg;
        end
    end

    // update arithmetic
    logic signed [VAL_W-1:0] boot;
    logic [VAL_W-1:0]        round_bias;
    logic signed [VAL_W-1:0] diff_biased;
    logic signed [VAL_W-1:0] lim_pos;
    logic signed [VAL_W-1:0] lim_neg;

    // bootstrap term: floor of gamma * max / 2^16, cut to 32 bits
    assign boot = done_reg ? '0 : prod_reg[FRAC_BITS +: VAL_W];
    // truncation toward zero: bias negative values before the shift
    assign round_bias  = ~({VAL_W{1'b1}} << learn_shift_reg);
    assign diff_biased = diff_reg + (diff_reg[VAL_W-1] ? $signed(round_bias) : '0);
    assign lim_pos     = $signed({1'b0, value_limit_reg});
    assign lim_neg     = -lim_pos;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
            prod_reg <= $signed({1'b0, discount_reg}) * best_val_reg;
        if (state_reg == ST_TARGET)
            target_reg <= reward_reg + boot;
        if (state_reg == ST_DIFF)
            diff_reg <= target_reg - qcur_reg;
        if (state_reg == ST_SCALE)
            delta_reg <= diff_biased >>> learn_shift_reg;
        if (state_reg == ST_SUM)
            sum_reg <= qcur_reg + delta_reg;
        if (state_reg == ST_CLAMP)
        begin
            priority if (sum_reg < lim_neg)
            begin
                newval_reg <= lim_neg;
                hit_reg    <= 1'b1;
            end
            else if (sum_reg > lim_pos)
            begin
                newval_reg <= lim_pos;
                hit_reg    <= 1'b1;
            end
            else
            begin
                newval_reg <= sum_reg;
                hit_reg    <= (sum_reg == lim_pos) || (sum_reg == lim_neg);
            end
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_act_reg <= cmd_reg ? best_idx_reg : act_reg;
            out_val_reg <= cmd_reg ? best_val_reg : newval_reg;
            out_hit_reg <= !cmd_reg && hit_reg;
            out_upd_reg <= upd_cnt_next;
            out_clp_reg <= clp_cnt_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({out_clp_reg, out_upd_reg, out_hit_reg, out_val_reg, out_act_reg});

    // no item while the clearing sweep runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input taken during table clear");

    // output register is never overwritten while still held
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> out_free)
        else $error("result word overwritten");

    // table read and write never share a cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_rd_en && mem_wr_en))
        else $error("table read and write collide");

    // each update result advances the update count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !cmd_reg) |=> (upd_cnt_reg == $past(upd_cnt_reg) + CNT_W'(1)))
        else $error("update count did not advance");

endmodule

`default_nettype wire
